FILE: hdl/tobb_pkg.sv
// Shared constants for the third-octave cascaded biquad band-pass core.
package tobb_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int STATE_WIDTH_DEF  = 48;

  // Coefficients are signed Q2.30.
  localparam int COEF_WIDTH = 32;
  localparam int COEF_FRAC  = 30;

  // Two high-pass biquads followed by two low-pass biquads.
  localparam int NUM_STAGES = 4;
  localparam int STAGE_W    = 2;

  // Configuration register indexes.
  localparam int NUM_REGS  = 6;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_HP_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HP_FB_ONE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HP_FB_TWO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LP_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LP_FB_ONE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LP_FB_TWO = 3'd5;

endpackage

FILE: hdl/third_octave_biquad_bandpass_core.sv
// Eighth-order band-pass: four transposed DF-II biquads on one shared multiplier.
// Each input sample passes through 8 sequencer steps per biquad and one output
// load step before output valid rises.
// A new sample is taken only in the idle step, once the last one has gone to the
// output register; the single shared multiplier sets this.
// A finished sample waits in the output register while the next one is taken.
// Reset (rst_ni low, asynchronous) clears coefficients and all delay state to zero.
module third_octave_biquad_bandpass_core #(
  parameter int SAMPLE_WIDTH = tobb_pkg::SAMPLE_WIDTH_DEF,
  parameter int STATE_WIDTH  = tobb_pkg::STATE_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tobb_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tobb_pkg::COEF_WIDTH-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample_in_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]     sample_out_o
);
  import tobb_pkg::*;

  localparam int PROD_W     = COEF_WIDTH + SAMPLE_WIDTH;
  localparam int STATE_FRAC = STATE_WIDTH - 4;
  localparam int PROD_SHIFT = COEF_FRAC + (SAMPLE_WIDTH - 1) - STATE_FRAC;
  localparam int SHIFT_R    = (PROD_SHIFT >= 0) ? PROD_SHIFT : 0;
  localparam int SHIFT_L    = (PROD_SHIFT >= 0) ? 0 : -PROD_SHIFT;
  localparam int OUT_SHIFT  = STATE_FRAC - (SAMPLE_WIDTH - 1);
  localparam int QW         = STATE_WIDTH - OUT_SHIFT;
  localparam int EXT_W      = QW - SAMPLE_WIDTH + 2;

  localparam logic signed [QW:0] SAT_MAX = {{EXT_W{1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [QW:0] SAT_MIN = {{EXT_W{1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

  // Sequencer steps; each biquad runs ST_MB through ST_S2.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MB   = 4'd1;  // b0 * x
  localparam logic [3:0] ST_TT   = 4'd2;  // scale to state format
  localparam logic [3:0] ST_YF   = 4'd3;  // t + first delay, middle term
  localparam logic [3:0] ST_YY   = 4'd4;  // round and saturate
  localparam logic [3:0] ST_M1   = 4'd5;  // a1 * y
  localparam logic [3:0] ST_S1   = 4'd6;  // mid - a1*y
  localparam logic [3:0] ST_M2   = 4'd7;  // a2 * y, first delay update
  localparam logic [3:0] ST_S2   = 4'd8;  // second delay update
  localparam logic [3:0] ST_FIN  = 4'd9;  // hand sample to output register

  logic [3:0]         state_q, state_d;
  logic [STAGE_W-1:0] stage_q;

  logic signed [COEF_WIDTH-1:0] hp_gain_q, hp_fb_one_q, hp_fb_two_q;
  logic signed [COEF_WIDTH-1:0] lp_gain_q, lp_fb_one_q, lp_fb_two_q;

  logic signed [STATE_WIDTH-1:0] first_delay_q  [NUM_STAGES];
  logic signed [STATE_WIDTH-1:0] second_delay_q [NUM_STAGES];

  logic signed [SAMPLE_WIDTH-1:0] x_q;
  logic signed [PROD_W-1:0]       prod_q;
  logic signed [STATE_WIDTH-1:0]  t_q, yf_q, mid_q, acc_q;

  logic signed [SAMPLE_WIDTH-1:0] sample_out_q;
  logic                           out_valid_q;

  logic                           is_lowpass;
  logic                           last_stage;
  logic signed [COEF_WIDTH-1:0]   mult_coef;
  logic signed [PROD_W-1:0]       mult_res;
  logic signed [63:0]             prod_ext;
  logic signed [63:0]             prod_shifted;
  logic signed [STATE_WIDTH-1:0]  prod_scaled;
  logic signed [QW-1:0]           q_trunc;
  logic signed [QW:0]             q_rnd;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;

  assign is_lowpass = stage_q[STAGE_W-1];
  assign last_stage = (stage_q == STAGE_W'(NUM_STAGES - 1));

  // Shared multiplier: coefficient chosen by the sequencer step.
  always_comb begin
    case (state_q)
      ST_M1:   mult_coef = is_lowpass ? lp_fb_one_q : hp_fb_one_q;
      ST_M2:   mult_coef = is_lowpass ? lp_fb_two_q : hp_fb_two_q;
      default: mult_coef = is_lowpass ? lp_gain_q : hp_gain_q;
    endcase
  end

  assign mult_res = mult_coef * x_q;

  // Truncate the registered product to the state format.
  assign prod_ext     = 64'(prod_q);
  assign prod_shifted = (prod_ext >>> SHIFT_R) <<< SHIFT_L;
  assign prod_scaled  = prod_shifted[STATE_WIDTH-1:0];

  // Round half up, then saturate to the sample range.
  assign q_trunc = yf_q[STATE_WIDTH-1:OUT_SHIFT];
  assign q_rnd   = (QW+1)'(q_trunc) + $signed({{QW{1'b0}}, yf_q[OUT_SHIFT-1]});

  always_comb begin
    if (q_rnd > SAT_MAX) begin
      y_sat = SAT_MAX[SAMPLE_WIDTH-1:0];
    end else if (q_rnd < SAT_MIN) begin
      y_sat = SAT_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      y_sat = q_rnd[SAMPLE_WIDTH-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_MB;
      ST_MB:   state_d = ST_TT;
      ST_TT:   state_d = ST_YF;
      ST_YF:   state_d = ST_YY;
      ST_YY:   state_d = ST_M1;
      ST_M1:   state_d = ST_S1;
      ST_S1:   state_d = ST_M2;
      ST_M2:   state_d = ST_S2;
      ST_S2:   state_d = last_stage ? ST_FIN : ST_MB;
      ST_FIN:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stage_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_S2) begin
        stage_q <= last_stage ? '0 : stage_q + 1'b1;
      end
    end
  end

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_gain_q   <= '0;
      hp_fb_one_q <= '0;
      hp_fb_two_q <= '0;
      lp_gain_q   <= '0;
      lp_fb_one_q <= '0;
      lp_fb_two_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_HP_GAIN:   hp_gain_q   <= cfg_data_i;
        REG_HP_FB_ONE: hp_fb_one_q <= cfg_data_i;
        REG_HP_FB_TWO: hp_fb_two_q <= cfg_data_i;
        REG_LP_GAIN:   lp_gain_q   <= cfg_data_i;
        REG_LP_FB_ONE: lp_fb_one_q <= cfg_data_i;
        REG_LP_FB_TWO: lp_fb_two_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Delay state of the four biquads.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        first_delay_q[i]  <= '0;
        second_delay_q[i] <= '0;
      end
    end else begin
      if (state_q == ST_M2) begin
        first_delay_q[stage_q] <= acc_q + second_delay_q[stage_q];
      end
      if (state_q == ST_S2) begin
        second_delay_q[stage_q] <= t_q - prod_scaled;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (in_valid_i) x_q <= sample_in_i;
      ST_MB:   prod_q <= mult_res;
      ST_TT:   t_q <= prod_scaled;
      ST_YF: begin
        yf_q  <= t_q + first_delay_q[stage_q];
        // The high-pass middle tap is negated, the low-pass one is not.
        mid_q <= is_lowpass ? (t_q <<< 1) : -(t_q <<< 1);
      end
      ST_YY:   x_q <= y_sat;
      ST_M1:   prod_q <= mult_res;
      ST_S1:   acc_q <= mid_q - prod_scaled;
      ST_M2:   prod_q <= mult_res;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_FIN && (!out_valid_q || out_ready_i)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN && (!out_valid_q || out_ready_i)) begin
      sample_out_q <= x_q;
    end
  end

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;

endmodule

FILE: hdl/tobb_checker.sv
// Port-level checks for the band-pass core, bound to its top level.
module tobb_checker #(
  parameter int SAMPLE_WIDTH = tobb_pkg::SAMPLE_WIDTH_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic signed [SAMPLE_WIDTH-1:0] sample_out_o
);
  import tobb_pkg::*;

  logic unused_stage_cnt;
  assign unused_stage_cnt = (NUM_STAGES == 0);

  // A new sample is held off while the four biquads are being worked through.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o ##1 !in_ready_o ##1 !in_ready_o)
    else $error("input taken again too soon after a transfer");

  // A result only appears at the end of a computation, never out of idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("output valid rose without a finished computation");

  // The output register holds while the consumer stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(sample_out_o))
    else $error("stalled output changed");

  // Nothing is emitted in the cycle right after a sample is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !out_valid_o) |=> !out_valid_o || unused_stage_cnt)
    else $error("output appeared right after an input transfer");

endmodule

bind third_octave_biquad_bandpass_core tobb_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_tobb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .sample_out_o (sample_out_o)
);

FILE: verif/third_octave_biquad_bandpass_core_tb.sv
// Self-checking testbench for the third-octave cascaded biquad band-pass core.
`timescale 1ns / 100ps
module third_octave_biquad_bandpass_core_tb;
  import tobb_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int ZW = STATE_WIDTH_DEF;
  localparam int PROD_SHIFT = COEF_FRAC + (SW - 1) - (ZW - 4);
  localparam int OUT_SHIFT = (ZW - 4) - (SW - 1);
  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 80;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 20;
  localparam real FS_HZ = 48000.0;
  localparam real PI = 3.141592653589793;
  localparam real BUTTER_Q = 0.7071067811865476;
  localparam real Q30_SCALE = 1073741824.0;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_SIX = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_SEVEN = 3'd7;
  localparam logic [COEF_WIDTH-1:0] COEF_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [COEF_WIDTH-1:0] COEF_NEG_MAX = 32'h8000_0000;

  typedef logic signed [SW-1:0] smp_t;
  typedef logic signed [ZW-1:0] acc_t;

  localparam smp_t SMP_HI = {1'b0, {(SW - 1){1'b1}}};
  localparam smp_t SMP_LO = {1'b1, {(SW - 1){1'b0}}};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [COEF_WIDTH-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  smp_t sample_in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b1;
  smp_t sample_out_o;

  // Mirror of the coefficient registers and of the per-stage delay registers.
  logic signed [COEF_WIDTH-1:0] coef_q [NUM_REGS];
  acc_t delay_one [NUM_STAGES];
  acc_t delay_two [NUM_STAGES];
  logic [COEF_WIDTH-1:0] coef_plan [NUM_REGS];
  smp_t band_out_q [$];
  smp_t band_expected;

  int samples_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int settings_loaded = 0;
  int quiet_cycles = 0;
  int long_hold = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  real tone_phase = 0.0;
  real tone_step = 0.1;
  real tone_amp = 4000000.0;

  third_octave_biquad_bandpass_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_in_i (sample_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_out_o(sample_out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Q2.30 coefficient times Q1.23 sample, truncated to the Q4.44 state format.
  function automatic acc_t coef_mul(input logic signed [COEF_WIDTH-1:0] c, input smp_t x);
    longint p;
    p = longint'(c) * longint'(x);
    p = p >>> PROD_SHIFT;
    return p[ZW-1:0];
  endfunction

  function automatic smp_t round_sat(input acc_t yf);
    longint q;
    q = yf;
    q = q >>> OUT_SHIFT;
    if (yf[OUT_SHIFT-1]) q = q + 1;
    if (q > longint'(SMP_HI)) q = longint'(SMP_HI);
    else if (q < longint'(SMP_LO)) q = longint'(SMP_LO);
    return q[SW-1:0];
  endfunction

  // One transposed DF-II section; all state sums wrap at the state width.
  function automatic smp_t biquad_stage(input int k, input smp_t x, input int base,
                                        input bit highpass);
    acc_t t;
    acc_t yf;
    acc_t twice;
    smp_t y;
    t = coef_mul(coef_q[base], x);
    yf = t + delay_one[k];
    y = round_sat(yf);
    twice = t <<< 1;
    if (highpass) twice = -twice;
    delay_one[k] = twice - coef_mul(coef_q[base + 1], y) + delay_two[k];
    delay_two[k] = t - coef_mul(coef_q[base + 2], y);
    return y;
  endfunction

  function automatic smp_t bandpass_predict(input smp_t x);
    smp_t v;
    v = biquad_stage(0, x, REG_HP_GAIN, 1'b1);
    v = biquad_stage(1, v, REG_HP_GAIN, 1'b1);
    v = biquad_stage(2, v, REG_LP_GAIN, 1'b0);
    v = biquad_stage(3, v, REG_LP_GAIN, 1'b0);
    return v;
  endfunction

  function automatic logic [COEF_WIDTH-1:0] to_q30(input real v);
    return $rtoi(v * Q30_SCALE);
  endfunction

  // Butterworth high-pass at the lower band corner, low-pass at the upper one.
  function automatic void plan_band(input real fc);
    real lo_hz;
    real hi_hz;
    real w;
    real cs;
    real alpha;
    real a0;
    lo_hz = fc / (2.0 ** (1.0 / 6.0));
    hi_hz = fc * (2.0 ** (1.0 / 6.0));
    w = 2.0 * PI * lo_hz / FS_HZ;
    cs = $cos(w);
    alpha = $sin(w) / (2.0 * BUTTER_Q);
    a0 = 1.0 + alpha;
    coef_plan[REG_HP_GAIN] = to_q30((1.0 + cs) / 2.0 / a0);
    coef_plan[REG_HP_FB_ONE] = to_q30(-2.0 * cs / a0);
    coef_plan[REG_HP_FB_TWO] = to_q30((1.0 - alpha) / a0);
    w = 2.0 * PI * hi_hz / FS_HZ;
    cs = $cos(w);
    alpha = $sin(w) / (2.0 * BUTTER_Q);
    a0 = 1.0 + alpha;
    coef_plan[REG_LP_GAIN] = to_q30((1.0 - cs) / 2.0 / a0);
    coef_plan[REG_LP_FB_ONE] = to_q30(-2.0 * cs / a0);
    coef_plan[REG_LP_FB_TWO] = to_q30((1.0 - alpha) / a0);
    tone_step = 2.0 * PI * fc * ($urandom_range(50, 200) / 100.0) / FS_HZ;
    tone_amp = ($urandom_range(5, 95) / 100.0) * 8388000.0;
    tone_phase = 0.0;
  endfunction

  // Mostly a noisy tone near the band, with full-range noise, rails and small values.
  function automatic smp_t pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0: v = $urandom_range(0, 1) ? int'(SMP_HI) : int'(SMP_LO);
      1, 2: v = $urandom();
      3, 4: v = int'($urandom_range(0, 8191)) - 4096;
      default: begin
        tone_phase = tone_phase + tone_step;
        v = $rtoi(tone_amp * $sin(tone_phase)) + int'($urandom_range(0, 63)) - 32;
      end
    endcase
    return v[SW-1:0];
  endfunction

  task automatic send_sample(input smp_t x);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_in_i <= x;
    do @(posedge clk_i); while (!in_ready_o);
    band_out_q.push_back(bandpass_predict(x));
    samples_sent++;
  endtask

  // Every sample yields one result, so an empty queue means the core is idle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (band_out_q.size() != 0) @(posedge clk_i);
  endtask

  // Leaves cfg_valid_i high so back-to-back writes run without a gap.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_WIDTH-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < NUM_REGS) coef_q[idx] = val;
  endtask

  task automatic load_coefs();
    for (int i = 0; i < NUM_REGS; i++) write_reg(CFG_IDX_W'(i), coef_plan[i]);
    cfg_valid_i <= 1'b0;
    settings_loaded++;
  endtask

  task automatic test_zero_coefs();
    send_sample(SMP_HI);
    send_sample(SMP_LO);
    send_sample(smp_t'(1));
    send_sample(smp_t'(-1));
    send_sample(smp_t'(24'h555555));
    send_sample(smp_t'(24'hAAAAAA));
  endtask

  // Distinct stable values in each register; the spare indexes must change nothing.
  task automatic test_register_map();
    coef_plan[REG_HP_GAIN] = 32'h4000_0000;
    coef_plan[REG_HP_FB_ONE] = 32'h2000_0000;
    coef_plan[REG_HP_FB_TWO] = 32'h1000_0000;
    coef_plan[REG_LP_GAIN] = 32'h3000_0000;
    coef_plan[REG_LP_FB_ONE] = 32'hE000_0000;
    coef_plan[REG_LP_FB_TWO] = 32'h0800_0000;
    wait_idle();
    write_reg(REG_SPARE_SIX, COEF_POS_MAX);
    write_reg(REG_SPARE_SEVEN, COEF_NEG_MAX);
    load_coefs();
    send_sample(SMP_HI);
    send_sample('0);
    send_sample('0);
    send_sample('0);
    send_sample(SMP_LO);
    send_sample('0);
    send_sample(smp_t'(1));
    send_sample(smp_t'(-1));
  endtask

  // Full-scale coefficients drive every stage into saturation and the state into wrap.
  task automatic test_coef_extremes();
    for (int pol = 0; pol < 2; pol++) begin
      for (int i = 0; i < NUM_REGS; i++) coef_plan[i] = pol ? COEF_NEG_MAX : COEF_POS_MAX;
      wait_idle();
      load_coefs();
      send_sample(SMP_HI);
      send_sample(SMP_LO);
      send_sample(SMP_HI);
      send_sample('0);
      send_sample(smp_t'(-1));
    end
  endtask

  task automatic test_band_sweep();
    real centers [5] = '{31.5, 250.0, 1000.0, 4000.0, 16000.0};
    foreach (centers[c]) begin
      plan_band(centers[c]);
      wait_idle();
      load_coefs();
      repeat (180) send_sample(pick_sample());
    end
  endtask

  // The output side holds off for a long stretch while samples keep coming.
  task automatic test_backpressure();
    plan_band(1000.0);
    wait_idle();
    load_coefs();
    gaps_on = 1'b0;
    long_hold = LONG_HOLD_CYCLES;
    repeat (30) send_sample(pick_sample());
    gaps_on = 1'b1;
  endtask

  task automatic test_random_coefs();
    for (int trial = 0; trial < 4; trial++) begin
      coef_plan[REG_HP_GAIN] = $urandom();
      coef_plan[REG_LP_GAIN] = $urandom();
      if (trial < 2) begin
        coef_plan[REG_HP_FB_ONE] = $urandom();
        coef_plan[REG_HP_FB_TWO] = $urandom();
        coef_plan[REG_LP_FB_ONE] = $urandom();
        coef_plan[REG_LP_FB_TWO] = $urandom();
      end else begin
        // Feedback within +-0.5 keeps the poles inside the unit circle.
        coef_plan[REG_HP_FB_ONE] = int'($urandom_range(0, 1 << 30)) - (1 << 29);
        coef_plan[REG_HP_FB_TWO] = int'($urandom_range(0, 1 << 30)) - (1 << 29);
        coef_plan[REG_LP_FB_ONE] = int'($urandom_range(0, 1 << 30)) - (1 << 29);
        coef_plan[REG_LP_FB_TWO] = int'($urandom_range(0, 1 << 30)) - (1 << 29);
      end
      wait_idle();
      write_reg($urandom_range(0, 1) ? REG_SPARE_SIX : REG_SPARE_SEVEN, $urandom());
      load_coefs();
      repeat (60) send_sample(pick_sample());
    end
  endtask

  task automatic test_steady_stream();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    plan_band(2500.0);
    wait_idle();
    load_coefs();
    repeat (200) send_sample(pick_sample());
  endtask

  initial begin : receiver
    int span;
    forever begin
      @(posedge clk_i);
      if (long_hold > 0) begin
        span = long_hold;
        long_hold = 0;
        out_ready_i <= 1'b0;
        repeat (span) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (band_out_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: output sample %0d arrived with no expected value (expected none)",
                   $time, sample_out_o);
      end else begin
        band_expected = band_out_q.pop_front();
        results_checked++;
        if (sample_out_o !== band_expected) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: sample_out mismatch: expected %0d actual %0d",
                     $time, band_expected, sample_out_o);
        end
      end
    end
  end

  // Ends the run if no transfer of any kind happens for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results still pending",
               $time, QUIET_LIMIT, band_out_q.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : main
    for (int i = 0; i < NUM_REGS; i++) coef_q[i] = '0;
    for (int k = 0; k < NUM_STAGES; k++) begin
      delay_one[k] = '0;
      delay_two[k] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_zero_coefs();
    test_register_map();
    test_coef_extremes();
    test_band_sweep();
    test_backpressure();
    test_random_coefs();
    test_steady_stream();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Run covered %0d samples under %0d coefficient sets; %0d outputs compared.",
             samples_sent, settings_loaded, results_checked);
    $display("It exercised zero and full-scale coefficients, five bands, spare registers,");
    $display("random coefficients and a %0d-cycle output stall.", LONG_HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
